[src/glos_pkg.sv]
// Shared types and constants for the grid line-of-sight raycast block.
`timescale 1ns / 1ps

package glos_pkg;

  // Field widths fixed by the request and result words
  localparam int COORD_W    = 11;
  localparam int MAT_W      = 6;
  localparam int SIZE_W     = 9;
  localparam int MASK_W     = 64;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;

  // Bresenham arithmetic widths
  localparam int DELTA_W = COORD_W + 2;
  localparam int ERR_W   = DELTA_W + 1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCKING_MASK = 2'd2;

  // Request types
  localparam logic REQ_WRITE   = 1'b0;
  localparam logic REQ_RAYCAST = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DISPATCH,
    ST_WR_CHK,
    ST_RAY,
    ST_RAY_TGT,
    ST_FINISH
  } state_t;

  // Which result the datapath captures
  typedef enum logic [1:0] {
    RS_WRITE,
    RS_OOB,
    RS_HIT,
    RS_CLEAR
  } res_sel_t;

  typedef struct packed {
    logic     clr_en;
    logic     load_req;
    logic     ray_step;
    logic     mem_we;
    logic     res_load;
    res_sel_t res_sel;
    logic     res_chg;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic is_ray;
    logic o_in;
    logic t_in;
    logic mat_ok;
    logic wr_diff;
    logic cur_at_t;
    logic pend_block;
  } status_t;

endpackage

[src/glos_if.sv]
// Request and response channel interfaces for the raycast block.
`timescale 1ns / 1ps

interface glos_req_if;
  import glos_pkg::*;

  logic                      valid;
  logic                      ready;
  logic                      req_type;
  logic signed [COORD_W-1:0] origin_x;
  logic signed [COORD_W-1:0] origin_y;
  logic signed [COORD_W-1:0] target_x;
  logic signed [COORD_W-1:0] target_y;
  logic [MAT_W-1:0]          write_material;

  modport source (
    output valid, req_type, origin_x, origin_y, target_x, target_y, write_material,
    input  ready
  );
  modport sink (
    input  valid, req_type, origin_x, origin_y, target_x, target_y, write_material,
    output ready
  );
endinterface

interface glos_rsp_if;
  import glos_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] hit_x;
  logic signed [COORD_W-1:0] hit_y;
  logic [MAT_W-1:0]          hit_material;
  logic                      blocked;
  logic                      cell_changed;

  modport source (
    output valid, hit_x, hit_y, hit_material, blocked, cell_changed,
    input  ready
  );
  modport sink (
    input  valid, hit_x, hit_y, hit_material, blocked, cell_changed,
    output ready
  );
endinterface

[src/grid_line_of_sight_raycast_unit.sv]
// Top level of the grid line-of-sight raycast unit; words run one at a time.
// A write inside the grid reads and checks its cell before the response; any other write,
// or a raycast with an endpoint outside, is answered from dispatch; a walk runs until it
// reaches the target or is blocked. A new word is accepted only once the response is loaded.
// Reset: synchronous; the grid is then zeroed one cell per cycle, while no request is taken;
// config writes are taken throughout.
`timescale 1ns / 1ps

module grid_line_of_sight_raycast_unit #(
  parameter int MAX_WIDTH      = 256,
  parameter int MAX_HEIGHT     = 256,
  parameter int MATERIAL_COUNT = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [glos_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [glos_pkg::CFG_DATA_W-1:0] cfg_data,
  glos_req_if.sink                        req,
  glos_rsp_if.source                      rsp
);
  import glos_pkg::*;

  cmd_t    cmd;
  status_t st;

  glos_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .st        (st),
    .cmd       (cmd)
  );

  glos_dp #(
    .MAX_WIDTH      (MAX_WIDTH),
    .MAX_HEIGHT     (MAX_HEIGHT),
    .MATERIAL_COUNT (MATERIAL_COUNT)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .req_type       (req.req_type),
    .origin_x       (req.origin_x),
    .origin_y       (req.origin_y),
    .target_x       (req.target_x),
    .target_y       (req.target_y),
    .write_material (req.write_material),
    .cmd            (cmd),
    .st             (st),
    .hit_x          (rsp.hit_x),
    .hit_y          (rsp.hit_y),
    .hit_material   (rsp.hit_material),
    .blocked        (rsp.blocked),
    .cell_changed   (rsp.cell_changed)
  );

endmodule

[src/glos_dp.sv]
// Datapath: config registers, grid memory, Bresenham stepper and result registers.
`timescale 1ns / 1ps

module glos_dp #(
  parameter int MAX_WIDTH      = 256,
  parameter int MAX_HEIGHT     = 256,
  parameter int MATERIAL_COUNT = 64
) (
  input  logic                                clk,
  input  logic                                rst,
  // configuration
  input  logic                                cfg_we,
  input  logic [glos_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [glos_pkg::CFG_DATA_W-1:0]     cfg_data,
  // request word
  input  logic                                req_type,
  input  logic signed [glos_pkg::COORD_W-1:0] origin_x,
  input  logic signed [glos_pkg::COORD_W-1:0] origin_y,
  input  logic signed [glos_pkg::COORD_W-1:0] target_x,
  input  logic signed [glos_pkg::COORD_W-1:0] target_y,
  input  logic [glos_pkg::MAT_W-1:0]          write_material,
  // control
  input  glos_pkg::cmd_t                      cmd,
  output glos_pkg::status_t                   st,
  // response word
  output logic signed [glos_pkg::COORD_W-1:0] hit_x,
  output logic signed [glos_pkg::COORD_W-1:0] hit_y,
  output logic [glos_pkg::MAT_W-1:0]          hit_material,
  output logic                                blocked,
  output logic                                cell_changed
);
  import glos_pkg::*;

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int XW    = $clog2(MAX_WIDTH);
  localparam int YW    = $clog2(MAX_HEIGHT);
  localparam logic [AW-1:0]      ROW_STRIDE = AW'(MAX_WIDTH);
  localparam logic [AW-1:0]      LAST_ADDR  = AW'(DEPTH - 1);
  localparam logic [COORD_W-1:0] MAX_W_C    = COORD_W'(MAX_WIDTH);
  localparam logic [COORD_W-1:0] MAX_H_C    = COORD_W'(MAX_HEIGHT);
  localparam logic [MAT_W:0]     MAT_LIMIT  = (MAT_W + 1)'(MATERIAL_COUNT);

  // Configuration registers
  logic [SIZE_W-1:0] grid_width;
  logic [SIZE_W-1:0] grid_height;
  logic [MASK_W-1:0] blocking_mask;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width    <= SIZE_W'(256);
      grid_height   <= SIZE_W'(256);
      blocking_mask <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GRID_WIDTH:    grid_width    <= cfg_data[SIZE_W-1:0];
        REG_GRID_HEIGHT:   grid_height   <= cfg_data[SIZE_W-1:0];
        REG_BLOCKING_MASK: blocking_mask <= cfg_data[MASK_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective grid size, saturated to the array bounds
  logic [COORD_W-1:0] gw_eff;
  logic [COORD_W-1:0] gh_eff;

  always_comb begin
    gw_eff = (COORD_W'(grid_width) > MAX_W_C) ? MAX_W_C : COORD_W'(grid_width);
    gh_eff = (COORD_W'(grid_height) > MAX_H_C) ? MAX_H_C : COORD_W'(grid_height);
  end

  // Request registers
  logic                      is_ray;
  logic signed [COORD_W-1:0] ox, oy, tx, ty;
  logic [MAT_W-1:0]          mat;

  // Bresenham state
  logic signed [COORD_W-1:0] cur_x, cur_y;
  logic signed [DELTA_W-1:0] dx, dy;
  logic                      sx_neg, sy_neg;
  logic signed [ERR_W-1:0]   err;

  // Pending grid read of the previous walk cell
  logic                      pend_v;
  logic signed [COORD_W-1:0] pend_x, pend_y;

  // Deltas from the incoming word
  logic signed [COORD_W:0]   diff_x, diff_y;
  logic signed [DELTA_W-1:0] abs_x, abs_y;

  always_comb begin
    diff_x = (COORD_W + 1)'(target_x) - (COORD_W + 1)'(origin_x);
    diff_y = (COORD_W + 1)'(target_y) - (COORD_W + 1)'(origin_y);
    abs_x  = diff_x[COORD_W] ? -DELTA_W'(diff_x) : DELTA_W'(diff_x);
    abs_y  = diff_y[COORD_W] ? -DELTA_W'(diff_y) : DELTA_W'(diff_y);
  end

  // One Bresenham step
  logic signed [ERR_W:0]     e2;
  logic                      step_x, step_y;
  logic signed [ERR_W-1:0]   err_next;
  logic signed [COORD_W-1:0] cur_x_next, cur_y_next;
  logic signed [COORD_W-1:0] inc_x, inc_y;

  always_comb begin
    e2         = {err, 1'b0};
    step_x     = e2 >= (ERR_W + 1)'(dy);
    step_y     = e2 <= (ERR_W + 1)'(dx);
    inc_x      = sx_neg ? -COORD_W'(1) : COORD_W'(1);
    inc_y      = sy_neg ? -COORD_W'(1) : COORD_W'(1);
    err_next   = err + (step_x ? ERR_W'(dy) : '0) + (step_y ? ERR_W'(dx) : '0);
    cur_x_next = step_x ? cur_x + inc_x : cur_x;
    cur_y_next = step_y ? cur_y + inc_y : cur_y;
  end

  logic cur_at_o;
  assign cur_at_o = (cur_x == ox) && (cur_y == oy);

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      is_ray <= req_type;
      ox     <= origin_x;
      oy     <= origin_y;
      tx     <= target_x;
      ty     <= target_y;
      mat    <= write_material;
      cur_x  <= origin_x;
      cur_y  <= origin_y;
      dx     <= abs_x;
      dy     <= -abs_y;
      sx_neg <= !(origin_x < target_x);
      sy_neg <= !(origin_y < target_y);
      err    <= ERR_W'(abs_x) - ERR_W'(abs_y);
    end else if (cmd.ray_step) begin
      cur_x  <= cur_x_next;
      cur_y  <= cur_y_next;
      err    <= err_next;
    end
  end

  // Pending read tracking; the origin is never read
  always_ff @(posedge clk) begin
    if (rst || cmd.load_req) begin
      pend_v <= 1'b0;
    end else if (cmd.ray_step) begin
      pend_v <= !cur_at_o;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ray_step) begin
      pend_x <= cur_x;
      pend_y <= cur_y;
    end
  end

  // Clearing counter
  logic [AW-1:0] clr_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clr_en) begin
      clr_cnt <= clr_cnt + AW'(1);
    end
  end

  // Grid memory, single port, registered read
  logic [MAT_W-1:0] grid_mem [DEPTH];
  logic [MAT_W-1:0] rdata;
  logic [AW-1:0]    cur_addr;
  logic [AW-1:0]    mem_addr;
  logic [MAT_W-1:0] mem_wdata;
  logic             mem_we;

  always_comb begin
    cur_addr  = AW'(cur_y[YW-1:0]) * ROW_STRIDE + AW'(cur_x[XW-1:0]);
    mem_addr  = cmd.clr_en ? clr_cnt : cur_addr;
    mem_wdata = cmd.clr_en ? '0 : mat;
    mem_we    = cmd.clr_en || cmd.mem_we;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      grid_mem[mem_addr] <= mem_wdata;
    end
    rdata <= grid_mem[mem_addr];
  end

  // Status
  logic o_in, t_in;

  always_comb begin
    o_in = !ox[COORD_W-1] && !oy[COORD_W-1] &&
           ($unsigned(ox) < gw_eff) && ($unsigned(oy) < gh_eff);
    t_in = !tx[COORD_W-1] && !ty[COORD_W-1] &&
           ($unsigned(tx) < gw_eff) && ($unsigned(ty) < gh_eff);
    st.clr_done   = clr_cnt == LAST_ADDR;
    st.is_ray     = is_ray;
    st.o_in       = o_in;
    st.t_in       = t_in;
    st.mat_ok     = {1'b0, mat} < MAT_LIMIT;
    st.wr_diff    = rdata != mat;
    st.cur_at_t   = (cur_x == tx) && (cur_y == ty);
    st.pend_block = pend_v && blocking_mask[rdata];
  end

  // Result capture
  logic signed [COORD_W-1:0] res_x, res_y;
  logic [MAT_W-1:0]          res_mat;
  logic                      res_blk, res_chg;

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      unique case (cmd.res_sel)
        RS_WRITE: begin
          res_x   <= '0;
          res_y   <= '0;
          res_mat <= '0;
          res_blk <= 1'b0;
          res_chg <= cmd.res_chg;
        end
        RS_OOB: begin
          res_x   <= o_in ? tx : ox;
          res_y   <= o_in ? ty : oy;
          res_mat <= '0;
          res_blk <= 1'b1;
          res_chg <= 1'b0;
        end
        RS_HIT: begin
          res_x   <= pend_x;
          res_y   <= pend_y;
          res_mat <= rdata;
          res_blk <= 1'b1;
          res_chg <= 1'b0;
        end
        RS_CLEAR: begin
          res_x   <= tx;
          res_y   <= ty;
          res_mat <= rdata;
          res_blk <= 1'b0;
          res_chg <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // Output word register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      hit_x        <= res_x;
      hit_y        <= res_y;
      hit_material <= res_mat;
      blocked      <= res_blk;
      cell_changed <= res_chg;
    end
  end

endmodule

[src/glos_ctrl.sv]
// Controller: sequences clearing, writes and raycast walks.
`timescale 1ns / 1ps

module glos_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  input  glos_pkg::status_t st,
  output glos_pkg::cmd_t    cmd
);
  import glos_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (st.clr_done) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (req_valid) state_next = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        if (!st.is_ray) begin
          state_next = (st.o_in && st.mat_ok) ? ST_WR_CHK : ST_FINISH;
        end else begin
          state_next = (st.o_in && st.t_in) ? ST_RAY : ST_FINISH;
        end
      end
      ST_WR_CHK: state_next = ST_FINISH;
      ST_RAY: begin
        if (st.pend_block) begin
          state_next = ST_FINISH;
        end else if (st.cur_at_t) begin
          state_next = ST_RAY_TGT;
        end
      end
      ST_RAY_TGT: state_next = ST_FINISH;
      ST_FINISH: begin
        if (!rsp_valid || rsp_ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd       = '0;
    req_ready = 1'b0;
    unique case (state)
      ST_CLEAR: cmd.clr_en = 1'b1;
      ST_IDLE: begin
        req_ready    = 1'b1;
        cmd.load_req = req_valid;
      end
      ST_DISPATCH: begin
        if (!st.is_ray) begin
          cmd.res_load = !(st.o_in && st.mat_ok);
          cmd.res_sel  = RS_WRITE;
        end else begin
          cmd.res_load = !(st.o_in && st.t_in);
          cmd.res_sel  = RS_OOB;
        end
      end
      ST_WR_CHK: begin
        cmd.mem_we   = st.wr_diff;
        cmd.res_load = 1'b1;
        cmd.res_sel  = RS_WRITE;
        cmd.res_chg  = st.wr_diff;
      end
      ST_RAY: begin
        if (st.pend_block) begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = RS_HIT;
        end else if (!st.cur_at_t) begin
          cmd.ray_step = 1'b1;
        end
      end
      ST_RAY_TGT: begin
        cmd.res_load = 1'b1;
        cmd.res_sel  = RS_CLEAR;
      end
      ST_FINISH: cmd.out_load = !rsp_valid || rsp_ready;
      default: ;
    endcase
  end

  // Response valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.out_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

endmodule
